/* rtl/ffa_pkg.sv */
// Shared types, constants and codes for the first-fit heap allocator.
// No dependencies; imported by every other file of the block.
package ffa_pkg;

    localparam int unsigned DEF_MAX_BLOCKS = 64;
    localparam logic [31:0] HDR_BYTES      = 32'd16;
    localparam logic [31:0] ALIGN_BYTES    = 32'd16;
    localparam logic [31:0] MIN_SPLIT      = 32'd32;
    localparam logic [32:0] GUARD_BYTES    = 33'd65536;
    localparam logic [31:0] DEFAULT_MEM    = 32'd16777216;
    localparam logic [31:0] RST_HEAP_BASE  = 32'd1048576;
    localparam logic [31:0] RST_TOTAL_MEM  = 32'd16777216;
    localparam logic [6:0]  CNT_MAX        = 7'd127;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_INIT  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic CFG_HEAP_BASE = 1'b0;
    localparam logic CFG_TOTAL_MEM = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_READY  = 3'd1,
        ST_ZERO_SIZE  = 3'd2,
        ST_NO_FIT     = 3'd3,
        ST_NULL_FREE  = 3'd4,
        ST_UNKNOWN    = 3'd5,
        ST_INIT_SMALL = 3'd6
    } t_status;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic        free;
    } t_entry;

endpackage

/* rtl/ffa_if.sv */
// Command and result channels of the heap allocator.
// Depends on ffa_pkg.
interface ffa_cmd_if;
    import ffa_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] request_bytes;
    logic [31:0] release_address;
    modport source (output valid, command, request_bytes, release_address, input ready);
    modport sink   (input valid, command, request_bytes, release_address, output ready);
endinterface

interface ffa_res_if;
    import ffa_pkg::*;
    logic        valid;
    logic        ready;
    logic [31:0] payload_address;
    logic [2:0]  status;
    logic [6:0]  live_allocations;
    logic [31:0] free_byte_total;
    logic        ready_res;
    modport source (output valid, payload_address, status, live_allocations,
                    free_byte_total, ready_res, input ready);
    modport sink   (input valid, payload_address, status, live_allocations,
                    free_byte_total, ready_res, output ready);
endinterface

/* rtl/ffa_table.sv */
// Block table memory: one write port, one read port, registered read data.
// Depends on ffa_pkg.
module ffa_table #(
    parameter int unsigned MAX_BLOCKS = ffa_pkg::DEF_MAX_BLOCKS,
    parameter int unsigned AW = $clog2(MAX_BLOCKS)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  ffa_pkg::t_entry    i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output ffa_pkg::t_entry    o_rdata
);
    import ffa_pkg::*;

    t_entry r_mem [MAX_BLOCKS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/first_fit_heap_allocator_core.sv */
// First-fit heap allocator: sequencer around the block table memory.
// From accept to result valid: early failures and unused commands go straight to the
// result; init writes the single entry; a search reads entries from index 0 upward;
// a split alloc shifts entries up; a free merges neighbours and moves entries down.
// Throughput: one command in flight; the next is taken the cycle after the result loads.
// Synchronous active-low reset clears control and counters; the table is
// not cleared and its entries are only used below the block count.
module first_fit_heap_allocator_core #(
    parameter int unsigned MAX_BLOCKS = ffa_pkg::DEF_MAX_BLOCKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    ffa_cmd_if.sink     s_cmd,
    ffa_res_if.source   m_res
);
    import ffa_pkg::*;

    localparam int unsigned AW = $clog2(MAX_BLOCKS);
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0] ONE      = CW'(1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_INIT  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_FRD   = 9'b000001000,
        S_FMG   = 9'b000010000,
        S_FWR   = 9'b000100000,
        S_SHIFT = 9'b001000000,
        S_POST  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state        r_state, n_state;
    logic [31:0]   r_hb, r_tmem;
    logic          r_alloc, n_alloc;
    logic [32:0]   r_want, n_want;
    logic [31:0]   r_addr, n_addr;
    logic [CW-1:0] r_i, n_i;
    t_entry        r_cur, n_cur, r_prev, n_prev;
    logic [CW-1:0] r_si, n_si, r_sidx, n_sidx;
    logic          r_sv, n_sv;
    logic [CW-1:0] r_count, n_count;
    logic [6:0]    r_cnt, n_cnt;
    logic [31:0]   r_ft, n_ft;
    logic          r_rdy, n_rdy;
    t_status       r_st, n_st;
    logic [31:0]   r_pay, n_pay;
    logic [CW-1:0] r_src, n_src, r_dst, n_dst, r_n, n_n, r_wdst, n_wdst;
    logic          r_up, n_up, r_pend, n_pend;
    logic          r_post_we, n_post_we;
    logic [CW-1:0] r_post_addr, n_post_addr;
    t_entry        r_post, n_post;
    logic [31:0]   r_s1, n_s1;
    logic          r_nf, n_nf, r_pf, n_pf;
    logic          r_ovld;
    logic [31:0]   r_o_pay, r_o_ft;
    t_status       r_o_st;
    logic [6:0]    r_o_cnt;
    logic          r_o_rdy;

    logic          we;
    logic [CW-1:0] waddr, raddr;
    t_entry        wdata, rdata;

    // scan / split / init / merge datapath
    logic          fit, fmatch, split;
    logic [31:0]   new_start, new_size;
    logic [32:0]   init_start, init_end;
    logic [31:0]   init_mem;
    logic          init_ok;
    logic          has_next;
    logic [1:0]    mcnt;
    logic [CW-1:0] m_dst, m_newc;

    ffa_table #(.MAX_BLOCKS(MAX_BLOCKS), .AW(AW)) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr[AW-1:0]),
        .o_rdata (rdata)
    );

    assign s_cmd.ready = (r_state == S_IDLE);

    always_comb begin
        fit    = r_sv && rdata.free && ({1'b0, rdata.size} >= r_want);
        fmatch = r_sv && !rdata.free && ((rdata.start + HDR_BYTES) == r_addr);
        split  = ({2'b00, rdata.size} >= ({1'b0, r_want} + {2'b00, HDR_BYTES}
                  + {2'b00, MIN_SPLIT})) && (r_count < CNT_FULL);
        new_start = rdata.start + HDR_BYTES + r_want[31:0];
        new_size  = rdata.size - r_want[31:0] - HDR_BYTES;
        init_mem   = (r_tmem == 32'd0) ? DEFAULT_MEM : r_tmem;
        init_start = ({1'b0, r_hb} + {1'b0, ALIGN_BYTES} - 33'd1) & ~{1'b0, ALIGN_BYTES - 32'd1};
        init_end   = {1'b0, init_mem & ~(ALIGN_BYTES - 32'd1)};
        if (init_end > GUARD_BYTES) begin
            init_end = init_end - GUARD_BYTES;
        end
        init_ok  = init_end > (init_start + {1'b0, HDR_BYTES});
        has_next = (r_i + ONE) < r_count;
        mcnt     = {1'b0, r_nf} + {1'b0, r_pf};
        m_dst    = r_pf ? r_i : r_i + ONE;
        m_newc   = r_count - CW'(mcnt);
    end

    always_comb begin
        n_state = r_state; n_alloc = r_alloc; n_want = r_want; n_addr = r_addr;
        n_i = r_i; n_cur = r_cur; n_prev = r_prev; n_si = r_si; n_sidx = r_sidx;
        n_sv = r_sv; n_count = r_count; n_cnt = r_cnt; n_ft = r_ft; n_rdy = r_rdy;
        n_st = r_st; n_pay = r_pay; n_src = r_src; n_dst = r_dst; n_n = r_n;
        n_wdst = r_wdst; n_up = r_up; n_pend = r_pend; n_post_we = r_post_we;
        n_post_addr = r_post_addr; n_post = r_post; n_s1 = r_s1; n_nf = r_nf;
        n_pf = r_pf;
        we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (s_cmd.valid) begin
                    n_pay = 32'd0;
                    n_st  = ST_OK;
                    n_si  = '0;
                    n_sv  = 1'b0;
                    n_alloc = (s_cmd.command == CMD_ALLOC);
                    n_addr  = s_cmd.release_address;
                    n_want  = ({1'b0, s_cmd.request_bytes} + {1'b0, ALIGN_BYTES} - 33'd1)
                              & ~{1'b0, ALIGN_BYTES - 32'd1};
                    n_state = S_DONE;
                    case (s_cmd.command)
                        CMD_ALLOC: begin
                            if (!r_rdy) begin
                                n_st = ST_NOT_READY;
                            end else if (s_cmd.request_bytes == 32'd0) begin
                                n_st = ST_ZERO_SIZE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_FREE: begin
                            if (s_cmd.release_address == 32'd0) begin
                                n_st = ST_NULL_FREE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_INIT: n_state = S_INIT;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_INIT: begin
                n_cnt   = 7'd0;
                n_rdy   = init_ok;
                n_count = init_ok ? ONE : '0;
                n_ft    = init_ok ? 32'(init_end - init_start - {1'b0, HDR_BYTES}) : 32'd0;
                n_st    = init_ok ? ST_OK : ST_INIT_SMALL;
                we      = init_ok;
                wdata   = '{start: init_start[31:0],
                            size: 32'(init_end - init_start - {1'b0, HDR_BYTES}),
                            free: 1'b1};
                n_state = S_DONE;
            end
            S_SCAN: begin
                raddr = r_si;
                if (r_si < r_count) begin
                    n_sv = 1'b1; n_sidx = r_si; n_si = r_si + ONE;
                end else begin
                    n_sv = 1'b0;
                end
                if (r_alloc && fit) begin
                    we    = 1'b1;
                    waddr = r_sidx;
                    wdata = '{start: rdata.start, size: split ? r_want[31:0] : rdata.size,
                              free: 1'b0};
                    n_pay = rdata.start + HDR_BYTES;
                    n_cnt = (r_cnt != CNT_MAX) ? r_cnt + 7'd1 : r_cnt;
                    n_ft  = r_ft - rdata.size + (split ? new_size : 32'd0);
                    if (split) begin
                        n_count = r_count + ONE;
                        n_post_we = 1'b1;
                        n_post_addr = r_sidx + ONE;
                        n_post = '{start: new_start, size: new_size, free: 1'b1};
                        n_up = 1'b1; n_src = r_count - ONE; n_dst = r_count;
                        n_n = r_count - r_sidx - ONE; n_pend = 1'b0;
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (!r_alloc && fmatch) begin
                    n_i = r_sidx; n_cur = rdata;
                    n_state = S_FRD;
                end else begin
                    if (r_sv) begin
                        n_prev = rdata;
                    end
                    if (!r_sv && !(r_si < r_count)) begin
                        n_st = r_alloc ? ST_NO_FIT : ST_UNKNOWN;
                        n_state = S_DONE;
                    end
                end
            end
            S_FRD: begin
                raddr = r_i + ONE;
                n_state = S_FMG;
            end
            S_FMG: begin
                n_nf  = has_next && rdata.free;
                n_pf  = (r_i != '0) && r_prev.free;
                n_s1  = r_cur.size + ((has_next && rdata.free) ? HDR_BYTES + rdata.size : 32'd0);
                n_ft  = r_ft + r_cur.size + ((has_next && rdata.free) ? HDR_BYTES : 32'd0);
                n_cnt = (r_cnt != 7'd0) ? r_cnt - 7'd1 : r_cnt;
                n_state = S_FWR;
            end
            S_FWR: begin
                we = 1'b1;
                if (r_pf) begin
                    waddr = r_i - ONE;
                    wdata = '{start: r_prev.start, size: r_prev.size + HDR_BYTES + r_s1,
                              free: 1'b1};
                    n_ft = r_ft + HDR_BYTES;
                end else begin
                    waddr = r_i;
                    wdata = '{start: r_cur.start, size: r_s1, free: 1'b1};
                end
                n_count = m_newc;
                n_up = 1'b0; n_dst = m_dst; n_src = m_dst + CW'(mcnt);
                n_n = (mcnt == 2'd0) ? '0 : m_newc - m_dst;
                n_pend = 1'b0; n_post_we = 1'b0;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                raddr = r_src;
                if (r_pend) begin
                    we = 1'b1; waddr = r_wdst; wdata = rdata;
                end
                if (r_n != '0) begin
                    n_pend = 1'b1; n_wdst = r_dst;
                    n_src = r_up ? r_src - ONE : r_src + ONE;
                    n_dst = r_up ? r_dst - ONE : r_dst + ONE;
                    n_n = r_n - ONE;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = r_post_we ? S_POST : S_DONE;
                    end
                end
            end
            S_POST: begin
                we = 1'b1; waddr = r_post_addr; wdata = r_post;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovld || m_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hb    <= RST_HEAP_BASE;
            r_tmem  <= RST_TOTAL_MEM;
            r_count <= '0;
            r_cnt   <= 7'd0;
            r_ft    <= 32'd0;
            r_rdy   <= 1'b0;
            r_sv    <= 1'b0;
            r_pend  <= 1'b0;
            r_post_we <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_idx == CFG_HEAP_BASE) begin
                r_hb <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == CFG_TOTAL_MEM) begin
                r_tmem <= i_cfg_data;
            end
            r_count <= n_count;
            r_cnt   <= n_cnt;
            r_ft    <= n_ft;
            r_rdy   <= n_rdy;
            r_sv    <= n_sv;
            r_pend  <= n_pend;
            r_post_we <= n_post_we;
            if (r_state == S_DONE && (!r_ovld || m_res.ready)) begin
                r_ovld <= 1'b1;
            end else if (m_res.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_alloc <= n_alloc; r_want <= n_want; r_addr <= n_addr; r_i <= n_i;
        r_cur <= n_cur; r_prev <= n_prev; r_si <= n_si; r_sidx <= n_sidx;
        r_st <= n_st; r_pay <= n_pay; r_src <= n_src; r_dst <= n_dst; r_n <= n_n;
        r_wdst <= n_wdst; r_up <= n_up; r_post_addr <= n_post_addr; r_post <= n_post;
        r_s1 <= n_s1; r_nf <= n_nf; r_pf <= n_pf;
        if (r_state == S_DONE && (!r_ovld || m_res.ready)) begin
            r_o_pay <= r_pay;
            r_o_st  <= r_st;
            r_o_cnt <= r_cnt;
            r_o_ft  <= r_ft;
            r_o_rdy <= r_rdy;
        end
    end

    assign m_res.valid            = r_ovld;
    assign m_res.payload_address  = r_o_pay;
    assign m_res.status           = r_o_st;
    assign m_res.live_allocations = r_o_cnt;
    assign m_res.free_byte_total  = r_o_ft;
    assign m_res.ready_res        = r_o_rdy;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL) else $error("block count beyond table depth");
    a_ready_has_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rdy |-> (r_count != '0)) else $error("ready heap with empty table");
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_res.valid && m_res.status != ST_OK) |-> (m_res.payload_address == 32'd0))
        else $error("failed command returned an address");
    a_notready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_res.valid && !m_res.ready_res) |-> (m_res.live_allocations == 7'd0))
        else $error("live allocations on heap not ready");

endmodule

/* dv/ffa_checker.sv */
// Checker for the first-fit heap allocator: watches the command and result
// channels, keeps its own copy of the block table and compares each result.
// Depends on ffa_pkg and the ffa_cmd_if / ffa_res_if interfaces.
module ffa_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    ffa_cmd_if          cmd,
    ffa_res_if          res,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ffa_pkg::*;

    localparam int NB = DEF_MAX_BLOCKS;

    typedef struct packed {
        logic [31:0] addr;
        logic [2:0]  status;
        logic [6:0]  live;
        logic [31:0] free_tot;
        logic        rdy;
    } t_outcome;

    logic [31:0] heap_base_q, total_mem_q;
    logic [31:0] tbl_start [NB];
    logic [31:0] tbl_size  [NB];
    logic        tbl_free  [NB];
    int          n_blocks;
    logic [6:0]  live_q;
    logic [31:0] free_sum;
    logic        heap_rdy;
    t_outcome    outcome_q [$];

    assign o_pending = outcome_q.size();

    function automatic void drop_entry(int idx);
        for (int k = idx; k + 1 < n_blocks; k++) begin
            tbl_start[k] = tbl_start[k+1];
            tbl_size[k]  = tbl_size[k+1];
            tbl_free[k]  = tbl_free[k+1];
        end
        if (n_blocks > 0) n_blocks--;
    endfunction

    function automatic void merge_next(int idx);
        if (idx + 1 >= n_blocks || !tbl_free[idx+1]) return;
        tbl_size[idx] = tbl_size[idx] + HDR_BYTES + tbl_size[idx+1];
        free_sum = free_sum + HDR_BYTES;
        drop_entry(idx + 1);
    endfunction

    function automatic t_outcome apply_command(logic [1:0] c, logic [31:0] req,
                                               logic [31:0] rel);
        t_outcome o;
        logic [63:0] want, mem, lo, hi;
        bit done;
        o = '0;
        done = 0;
        case (c)
            CMD_ALLOC: begin
                if (!heap_rdy) o.status = ST_NOT_READY;
                else if (req == 0) o.status = ST_ZERO_SIZE;
                else begin
                    want = ((64'(req) + 15) / 16) * 16;
                    for (int i = 0; i < n_blocks && !done; i++) begin
                        if (tbl_free[i] && 64'(tbl_size[i]) >= want) begin
                            done = 1;
                            free_sum = free_sum - tbl_size[i];
                            if (64'(tbl_size[i]) >= want + HDR_BYTES + MIN_SPLIT
                                && n_blocks < NB) begin
                                for (int k = n_blocks; k > i + 1; k--) begin
                                    tbl_start[k] = tbl_start[k-1];
                                    tbl_size[k]  = tbl_size[k-1];
                                    tbl_free[k]  = tbl_free[k-1];
                                end
                                tbl_start[i+1] = tbl_start[i] + HDR_BYTES + want[31:0];
                                tbl_size[i+1]  = tbl_size[i] - want[31:0] - HDR_BYTES;
                                tbl_free[i+1]  = 1'b1;
                                n_blocks++;
                                tbl_size[i] = want[31:0];
                                free_sum = free_sum + tbl_size[i+1];
                            end
                            tbl_free[i] = 1'b0;
                            if (live_q < CNT_MAX) live_q++;
                            o.addr = tbl_start[i] + HDR_BYTES;
                        end
                    end
                    o.status = done ? ST_OK : ST_NO_FIT;
                end
            end
            CMD_FREE: begin
                if (rel == 0) o.status = ST_NULL_FREE;
                else begin
                    for (int i = 0; i < n_blocks && !done; i++) begin
                        if (tbl_start[i] + HDR_BYTES == rel && !tbl_free[i]) begin
                            done = 1;
                            tbl_free[i] = 1'b1;
                            if (live_q > 0) live_q--;
                            free_sum = free_sum + tbl_size[i];
                            merge_next(i);
                            if (i > 0 && tbl_free[i-1]) merge_next(i - 1);
                        end
                    end
                    o.status = done ? ST_OK : ST_UNKNOWN;
                end
            end
            CMD_INIT: begin
                mem = (total_mem_q != 0) ? 64'(total_mem_q) : 64'(DEFAULT_MEM);
                lo = ((64'(heap_base_q) + 15) / 16) * 16;
                hi = (mem / 16) * 16;
                heap_rdy = 0; n_blocks = 0; live_q = 0; free_sum = 0;
                if (hi > 64'(GUARD_BYTES)) hi = hi - 64'(GUARD_BYTES);
                if (hi <= lo + HDR_BYTES) o.status = ST_INIT_SMALL;
                else begin
                    tbl_start[0] = lo[31:0];
                    tbl_size[0]  = 32'(hi - lo - HDR_BYTES);
                    tbl_free[0]  = 1'b1;
                    n_blocks = 1;
                    free_sum = tbl_size[0];
                    heap_rdy = 1;
                    o.status = ST_OK;
                end
            end
            default: o.status = ST_OK;
        endcase
        o.live = live_q;
        o.free_tot = free_sum;
        o.rdy = heap_rdy;
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_outcome e;
        if (!i_rst_n) begin
            heap_base_q <= RST_HEAP_BASE;
            total_mem_q <= RST_TOTAL_MEM;
            n_blocks = 0; live_q = 0; free_sum = 0; heap_rdy = 0;
            outcome_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_HEAP_BASE) heap_base_q <= i_cfg_data;
                else total_mem_q <= i_cfg_data;
            end
            if (cmd.valid && cmd.ready)
                outcome_q.push_back(apply_command(cmd.command, cmd.request_bytes,
                                                  cmd.release_address));
            if (res.valid && res.ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = outcome_q.pop_front();
                    if (e != {res.payload_address, res.status, res.live_allocations,
                              res.free_byte_total, res.ready_res}) begin
                        if (e.addr != res.payload_address)
                            $error("payload_address exp %h got %h", e.addr,
                                   res.payload_address);
                        if (e.status != res.status)
                            $error("status exp %0d got %0d", e.status, res.status);
                        if (e.live != res.live_allocations)
                            $error("live_allocations exp %0d got %0d", e.live,
                                   res.live_allocations);
                        if (e.free_tot != res.free_byte_total)
                            $error("free_byte_total exp %h got %h", e.free_tot,
                                   res.free_byte_total);
                        if (e.rdy != res.ready_res)
                            $error("ready_res exp %0d got %0d", e.rdy, res.ready_res);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* dv/tb_first_fit_heap_allocator_core.sv */
// Top of the heap allocator testbench: clock, reset, configuration writes,
// command stimulus and verdict. Depends on ffa_pkg, the interfaces and ffa_checker.
module tb_first_fit_heap_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;
    import ffa_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_HEAP_BASE;
    logic [31:0] i_cfg_data = '0;
    int          fail_count, pending;
    int          send_idle_pct, recv_idle_pct;
    int          quiet_cycles;
    bit          timed_out;
    logic [31:0] live_ptrs [$];

    ffa_cmd_if cmd_ch();
    ffa_res_if res_ch();

    first_fit_heap_allocator_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .s_cmd(cmd_ch.sink), .m_res(res_ch.source)
    );

    ffa_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .cmd(cmd_ch), .res(res_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_INIT;
        cmd_ch.request_bytes = '0;
        cmd_ch.release_address = '0;
        res_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (cmd_ch.valid || pending != 0)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("tb_first_fit_heap_allocator_core NOT OK");
            $finish;
        end
    end

    // valid stays high between back-to-back transfers and drops only for idle gaps
    task automatic send(logic [1:0] c, logic [31:0] req, logic [31:0] rel);
        if ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= c;
        cmd_ch.request_bytes <= req;
        cmd_ch.release_address <= rel;
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    task automatic quiesce();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_size();
        case ($urandom_range(9))
            0: return $urandom_range(1, 16);
            1: return $urandom;
            2: return $urandom_range(1, 1 << 20);
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    task automatic random_mix(int n);
        int j;
        logic [31:0] p;
        repeat (n) begin
            case ($urandom_range(19))
                0: send(CMD_INIT, $urandom, $urandom);
                1: send(CMD_NOP, $urandom, $urandom);
                2: send(CMD_FREE, $urandom, $urandom);
                3: send(CMD_FREE, $urandom, 32'd0);
                4, 5, 6, 7, 8, 9, 10, 11: send(CMD_ALLOC, pick_size(), $urandom);
                default: begin
                    if (live_ptrs.size() == 0) send(CMD_ALLOC, pick_size(), 0);
                    else begin
                        j = $urandom_range(live_ptrs.size() - 1);
                        p = live_ptrs[j];
                        // keep some stale pointers around to hit double free
                        if ($urandom_range(3) != 0) live_ptrs.delete(j);
                        send(CMD_FREE, $urandom, p);
                    end
                end
            endcase
        end
    endtask

    always @(posedge i_clk)
        if (res_ch.valid && res_ch.ready && res_ch.status == ST_OK
            && res_ch.payload_address != 0)
            live_ptrs.push_back(res_ch.payload_address);

    initial begin
        send_idle_pct = 9;
        recv_idle_pct = 45;
        quiet_cycles = 0;
        timed_out = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: before init, then defaults
        send(CMD_ALLOC, 32'd64, 0);
        send(CMD_FREE, 0, 32'h0010_0010);
        send(CMD_NOP, '1, '1);
        send(CMD_INIT, 0, 0);
        send(CMD_ALLOC, 32'd0, 0);
        send(CMD_ALLOC, 32'd1, 0);
        send(CMD_ALLOC, 32'd17, 0);
        send(CMD_ALLOC, 32'hFFFF_FFFF, 0);
        send(CMD_ALLOC, 32'hFFFF_FFF0, 0);
        send(CMD_FREE, 0, 32'd0);
        send(CMD_FREE, 0, 32'hFFFF_FFFF);
        send(CMD_FREE, 0, 32'h0010_0010);
        send(CMD_FREE, 0, 32'h0010_0010);
        send(CMD_FREE, 0, 32'h0010_0030);
        send(CMD_FREE, 0, 32'h0010_0040);
        // fill table past capacity to reach the no-split path
        repeat (70) send(CMD_ALLOC, 32'd16, 0);
        send(CMD_ALLOC, 32'h00F0_0000, 0);
        quiesce();
        live_ptrs.delete();

        // extremes of both registers, each followed by an init
        write_reg(CFG_HEAP_BASE, 32'hFFFF_FFFF);
        write_reg(CFG_TOTAL_MEM, 32'hFFFF_FFFF);
        send(CMD_INIT, 0, 0);
        send(CMD_ALLOC, 32'd1, 0);
        quiesce();
        write_reg(CFG_HEAP_BASE, 32'd0);
        write_reg(CFG_TOTAL_MEM, 32'd0);
        send(CMD_INIT, 0, 0);
        send(CMD_ALLOC, 32'h00FF_0000, 0);
        quiesce();
        write_reg(CFG_HEAP_BASE, 32'd1);
        write_reg(CFG_TOTAL_MEM, 32'h0001_0040);
        send(CMD_INIT, 0, 0);
        quiesce();

        // random phases: small heaps keep no-fit and full-table cases frequent
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2) begin send_idle_pct = 45; recv_idle_pct = 9; end
            if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
            live_ptrs.delete();
            write_reg(CFG_HEAP_BASE, (ph % 2) ? $urandom : $urandom_range(0, 1 << 20));
            write_reg(CFG_TOTAL_MEM, (ph % 2) ? $urandom :
                      32'h0001_0000 + $urandom_range(64, 1 << 16) + (1 << 20));
            send(CMD_INIT, 0, 0);
            quiesce();
            write_reg(CFG_HEAP_BASE, 32'd0);
            random_mix(240);
            quiesce();
        end

        if (fail_count == 0)
            $display("tb_first_fit_heap_allocator_core OK");
        else
            $display("tb_first_fit_heap_allocator_core NOT OK");
        $finish;
    end
endmodule
